// ===== hdl/rfsc_pkg.sv =====
package rfsc_pkg;

  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RANGE_W    = 24;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CMD_W      = 17;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned WGT_W      = 17;
  localparam int unsigned TYPE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned MUL_W      = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned ACC_W      = 41;
  localparam int unsigned DIV_W      = 34;
  localparam int unsigned DIV_CNT_W  = 6;
  localparam int unsigned TC_W       = 25;
  localparam int unsigned DS_W       = 26;

  localparam logic [TYPE_W-1:0] REQ_LEAD  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_RADIO = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_TICK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_UPDATED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INACTIVE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPEED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_THR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORM_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLOSURE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLOSURE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_APPROACH   = 3'd7;

  localparam logic [SPEED_W-1:0] RST_LEAD_SPEED     = 16'd5120;
  localparam logic [RANGE_W-1:0] RST_INTERCEPT_THR  = 24'd25600;
  localparam logic [RANGE_W-1:0] RST_TRANSITION_THR = 24'd7680;
  localparam logic [RANGE_W-1:0] RST_FORM_OFFSET    = 24'd2560;
  localparam logic [SPEED_W-1:0] RST_MIN_CLOSURE    = 16'd256;
  localparam logic [SPEED_W-1:0] RST_MAX_CLOSURE    = 16'd2560;
  localparam logic [SPEED_W-1:0] RST_MAX_APPROACH   = 16'd7680;

  localparam logic [WGT_W-1:0]   SMOOTH_WEIGHT_Q16 = 17'd19661;
  localparam logic [TIME_W-1:0]  RADIO_TIMEOUT_MS  = 32'd1000;
  localparam logic [TIME_W-1:0]  LEAD_TIMEOUT_MS   = 32'd2000;
  localparam logic [RANGE_W-1:0] RADIO_MAX_RANGE   = 24'd51200;

  localparam logic [WGT_W-1:0]   Q16_ONE  = 17'd65536;
  localparam logic [WGT_W-1:0]   Q16_HALF = 17'd32768;
  localparam logic [WGT_W-1:0]   W_NEAR   = 17'd52429;
  localparam logic [RANGE_W-1:0] R_NEAR   = 24'd12800;
  localparam logic [RANGE_W-1:0] R_MID    = 24'd25600;

  // floor(n / c) = (n * ceil(2^s / c)) >> s, exact over the operand ranges used
  localparam logic [MUL_W-1:0] RECIP_1000 = 32'd34359739;   // s = 35
  localparam logic [MUL_W-1:0] RECIP_100  = 32'd42949673;   // s = 32
  localparam logic [MUL_W-1:0] RECIP_10   = 32'd429496730;  // s = 32
  localparam logic [MUL_W-1:0] RECIP_5    = 32'd858993460;  // s = 32
  localparam logic [MUL_W-1:0] MS_PER_S   = 32'd1000;

  localparam logic [DIV_W-1:0]  RATE_POS_LIM = 34'd8388607;
  localparam logic [DIV_W-1:0]  RATE_NEG_LIM = 34'd8388608;
  localparam logic [RATE_W-1:0] RATE_MAX     = 24'h7FFFFF;
  localparam logic [RATE_W-1:0] RATE_MIN     = 24'h800000;
  localparam logic [CMD_W-1:0]  CMD_MAX      = 17'h1FFFF;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RADIO,
    S_WGT,
    S_WGT2,
    S_FUSE1,
    S_FUSE2,
    S_FUSE3,
    S_SMOOTH,
    S_SM2,
    S_SM3,
    S_DIFF,
    S_DIVLD,
    S_DIV,
    S_RATE,
    S_SPEED,
    S_SP2,
    S_EMIT
  } state_e;

endpackage

// ===== hdl/range_fusion_speed_command_top.sv =====
// Lead update and radio sample beats are taken in S_IDLE and give no result.
// A control tick goes from S_CHECK straight to S_EMIT when inactive or timed out; otherwise it
// runs weighting, fusion, smoothing, the closure division (34-step divider) when due, and the speed law.
// The next beat can be taken in the cycle after the result is emitted; an output stall holds S_EMIT.
// One shared 32x32 multiplier serves all blends and constant divisions; one item at a time.
// Reset (rst_ni low, asynchronous) clears all tracking state and loads register defaults.
module range_fusion_speed_command_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rfsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rfsc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // now_ms[31:0], gps_rng[55:32], radio_range[79:56]
  input  logic [rfsc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // req_type[1:0]
  input  logic [rfsc_pkg::TYPE_W-1:0]         s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // fused_range[23:0], closure_rate[47:24], speed_cmd[64:48], radio_used[65], zero[71:66]
  output logic [rfsc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // status[1:0]
  output logic [rfsc_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import rfsc_pkg::*;

  state_e state_q, state_d;

  logic               enable_q;
  logic [SPEED_W-1:0] lead_speed_q, min_closure_q, max_closure_q, max_approach_q;
  logic [RANGE_W-1:0] intercept_q, transition_q, form_offset_q;

  logic               lead_ok_q, radio_ok_q, smoothed_started_q, previous_seen_q;
  logic [TIME_W-1:0]  lead_stamp_q, radio_stamp_q, last_tick_q;
  logic [RANGE_W-1:0] radio_value_q, smoothed_range_q, previous_range_q;

  logic [TIME_W-1:0]   now_q, dt_q;
  logic [RANGE_W-1:0]  gps_q, fused_q;
  logic [WGT_W-1:0]    a_q;
  logic [PROD_W-1:0]   mul_q;
  logic [ACC_W-1:0]    acc_q;
  logic                neg_q;
  logic [DIV_W-1:0]    div_num_q;
  logic [TIME_W-1:0]   div_rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [RATE_W-1:0]   rate_q;
  logic [CMD_W-1:0]    speed_q;
  logic [STATUS_W-1:0] res_status_q;
  logic                out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic [STATUS_W-1:0] out_user_q;

  logic [MUL_W-1:0] mul_a, mul_b;

  logic [TYPE_W-1:0]  in_type;
  logic [TIME_W-1:0]  in_now;
  logic [RANGE_W-1:0] in_gps, in_radio;
  logic               in_fire, emit_fire;

  assign in_type  = s_axis_tuser;
  assign in_now   = s_axis_tdata[31:0];
  assign in_gps   = s_axis_tdata[55:32];
  assign in_radio = s_axis_tdata[79:56];
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready);

  logic [TIME_W-1:0] lead_age, radio_age;
  logic              lead_expired, radio_expired, active;

  assign lead_age      = now_q - lead_stamp_q;
  assign radio_age     = now_q - radio_stamp_q;
  assign lead_expired  = lead_age > LEAD_TIMEOUT_MS;
  assign radio_expired = radio_age > RADIO_TIMEOUT_MS;
  assign active        = enable_q && lead_ok_q;

  // radio weight
  logic               in_near, in_mid, in_far;
  logic [RANGE_W-1:0] wdiff_near, wdiff_mid;
  logic [MUL_W-1:0]   wgt_n1, wgt_n2, d_far;
  logic [WGT_W-1:0]   d_mid, a_mid, a_far;

  assign in_near    = gps_q < R_NEAR;
  assign in_mid     = gps_q < R_MID;
  assign in_far     = gps_q < RADIO_MAX_RANGE;
  assign wdiff_near = gps_q - R_NEAR;
  assign wdiff_mid  = gps_q - R_MID;
  assign wgt_n1 = ({8'd0, wdiff_near} << 10) + ({8'd0, wdiff_near} << 9) + 32'd500;
  assign wgt_n2 = ({8'd0, wdiff_mid} << 7) + 32'd50;
  assign d_mid  = mul_q[51:35];
  assign a_mid  = W_NEAR - d_mid;
  assign d_far  = mul_q[63:32];
  assign a_far  = (d_far >= {15'd0, Q16_HALF}) ? '0 : (Q16_HALF - d_far[WGT_W-1:0]);

  logic [ACC_W-1:0] blend_sum;
  assign blend_sum = acc_q + mul_q[ACC_W-1:0] + {24'd0, Q16_HALF};

  // closure rate
  logic [RANGE_W:0]   diff;
  logic [RANGE_W:0]   diff_abs;
  logic               do_rate;
  logic [TIME_W:0]    rem_sh;
  logic               div_ge;
  logic [TIME_W:0]    rem_sub;
  logic [RATE_W-1:0]  rate_pos, rate_neg;

  assign diff     = {1'b0, previous_range_q} - {1'b0, smoothed_range_q};
  assign diff_abs = diff[RANGE_W] ? (~diff + 1'b1) : diff;
  assign do_rate  = (dt_q != '0) && previous_seen_q;
  assign rem_sh   = {div_rem_q, div_num_q[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dt_q};
  assign rem_sub  = rem_sh - {1'b0, dt_q};
  assign rate_pos = (div_num_q > RATE_POS_LIM) ? RATE_MAX : div_num_q[RATE_W-1:0];
  assign rate_neg = (div_num_q > RATE_NEG_LIM) ? RATE_MIN
                                               : (RATE_W'(0) - div_num_q[RATE_W-1:0]);

  // speed command
  logic               in_icpt, in_trans;
  logic [MUL_W-1:0]   sp_num;
  logic [TC_W-1:0]    tc, tc_min, tc_max, tcc_i, tcc_t;
  logic [DS_W-1:0]    ds_i, ds_ic, ds_t, ds_sel;
  logic [CMD_W-1:0]   speed_sp2;

  assign in_icpt  = smoothed_range_q > intercept_q;
  assign in_trans = smoothed_range_q > transition_q;
  assign sp_num = in_icpt ? ({8'd0, smoothed_range_q} + 32'd5)
                : (smoothed_range_q > form_offset_q)
                  ? ({8'd0, smoothed_range_q - form_offset_q} + 32'd2) : '0;
  assign tc     = mul_q[56:32];
  assign tc_min = {9'd0, min_closure_q};
  assign tc_max = {9'd0, max_closure_q};
  assign tcc_i  = (tc < tc_min) ? tc_min : ((tc > tc_max) ? tc_max : tc);
  assign tcc_t  = (tc < tc_min) ? tc_min : tc;
  assign ds_i   = {10'd0, lead_speed_q} + {1'b0, tcc_i};
  assign ds_ic  = (ds_i > {10'd0, max_approach_q}) ? {10'd0, max_approach_q} : ds_i;
  assign ds_t   = {10'd0, lead_speed_q} + {1'b0, tcc_t};
  assign ds_sel = in_icpt ? ds_ic : ds_t;
  assign speed_sp2 = (ds_sel > {9'd0, CMD_MAX}) ? CMD_MAX : ds_sel[CMD_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (in_type == REQ_TICK)) state_d = S_CHECK;
      end
      S_CHECK: begin
        priority if (!active)    state_d = S_EMIT;
        else if (lead_expired)   state_d = S_EMIT;
        else                     state_d = S_RADIO;
      end
      S_RADIO:  state_d = (radio_ok_q && !radio_expired) ? S_WGT : S_SMOOTH;
      S_WGT:    state_d = (in_near || !in_far) ? S_FUSE1 : S_WGT2;
      S_WGT2:   state_d = S_FUSE1;
      S_FUSE1:  state_d = S_FUSE2;
      S_FUSE2:  state_d = S_FUSE3;
      S_FUSE3:  state_d = S_SMOOTH;
      S_SMOOTH: state_d = smoothed_started_q ? S_SM2 : S_DIFF;
      S_SM2:    state_d = S_SM3;
      S_SM3:    state_d = S_DIFF;
      S_DIFF:   state_d = do_rate ? S_DIVLD : S_SPEED;
      S_DIVLD:  state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(1)) state_d = S_RATE;
      end
      S_RATE:   state_d = S_SPEED;
      S_SPEED:  state_d = (in_icpt || in_trans) ? S_SP2 : S_EMIT;
      S_SP2:    state_d = S_EMIT;
      S_EMIT: begin
        if (emit_fire) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // shared multiplier operands and handshake
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    s_axis_tready = (state_q == S_IDLE);
    unique case (state_q)
      S_WGT: begin
        if (in_mid) begin
          mul_a = wgt_n1;
          mul_b = RECIP_1000;
        end else begin
          mul_a = wgt_n2;
          mul_b = RECIP_100;
        end
      end
      S_FUSE1: begin
        mul_a = {15'd0, a_q};
        mul_b = {8'd0, radio_value_q};
      end
      S_FUSE2: begin
        mul_a = {15'd0, Q16_ONE - a_q};
        mul_b = {8'd0, gps_q};
      end
      S_SMOOTH: begin
        mul_a = {15'd0, SMOOTH_WEIGHT_Q16};
        mul_b = {8'd0, fused_q};
      end
      S_SM2: begin
        mul_a = {15'd0, Q16_ONE - SMOOTH_WEIGHT_Q16};
        mul_b = {8'd0, smoothed_range_q};
      end
      S_DIFF: begin
        mul_a = {8'd0, diff_abs[RANGE_W-1:0]};
        mul_b = MS_PER_S;
      end
      S_SPEED: begin
        mul_a = sp_num;
        mul_b = in_icpt ? RECIP_10 : RECIP_5;
      end
      default: begin
      end
    endcase
  end

  // configuration and tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= S_IDLE;
      enable_q           <= 1'b0;
      lead_speed_q       <= RST_LEAD_SPEED;
      intercept_q        <= RST_INTERCEPT_THR;
      transition_q       <= RST_TRANSITION_THR;
      form_offset_q      <= RST_FORM_OFFSET;
      min_closure_q      <= RST_MIN_CLOSURE;
      max_closure_q      <= RST_MAX_CLOSURE;
      max_approach_q     <= RST_MAX_APPROACH;
      lead_ok_q          <= 1'b0;
      lead_stamp_q       <= '0;
      radio_value_q      <= '0;
      radio_ok_q         <= 1'b0;
      radio_stamp_q      <= '0;
      smoothed_range_q   <= '0;
      smoothed_started_q <= 1'b0;
      previous_range_q   <= '0;
      previous_seen_q    <= 1'b0;
      last_tick_q        <= '0;
      div_cnt_q          <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ENABLE:         enable_q       <= cfg_data_i[0];
          CFG_LEAD_SPEED:     lead_speed_q   <= cfg_data_i[SPEED_W-1:0];
          CFG_INTERCEPT_THR:  intercept_q    <= cfg_data_i[RANGE_W-1:0];
          CFG_TRANSITION_THR: transition_q   <= cfg_data_i[RANGE_W-1:0];
          CFG_FORM_OFFSET:    form_offset_q  <= cfg_data_i[RANGE_W-1:0];
          CFG_MIN_CLOSURE:    min_closure_q  <= cfg_data_i[SPEED_W-1:0];
          CFG_MAX_CLOSURE:    max_closure_q  <= cfg_data_i[SPEED_W-1:0];
          CFG_MAX_APPROACH:   max_approach_q <= cfg_data_i[SPEED_W-1:0];
        endcase
      end

      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_type == REQ_LEAD) begin
              lead_ok_q    <= 1'b1;
              lead_stamp_q <= in_now;
            end
            if ((in_type == REQ_RADIO) && (in_radio != '0) && (in_radio < RADIO_MAX_RANGE)) begin
              radio_value_q <= in_radio;
              radio_ok_q    <= 1'b1;
              radio_stamp_q <= in_now;
            end
          end
        end
        S_CHECK: begin
          if (active && lead_expired) lead_ok_q <= 1'b0;
        end
        S_RADIO: begin
          if (radio_expired) radio_ok_q <= 1'b0;
        end
        S_SMOOTH: begin
          if (!smoothed_started_q) begin
            smoothed_range_q   <= fused_q;
            smoothed_started_q <= 1'b1;
          end
        end
        S_SM3: smoothed_range_q <= blend_sum[39:16];
        S_DIFF: begin
          previous_range_q <= smoothed_range_q;
          previous_seen_q  <= 1'b1;
          last_tick_q      <= now_q;
        end
        S_DIVLD: div_cnt_q <= DIV_CNT_W'(DIV_W);
        S_DIV:   div_cnt_q <= div_cnt_q - 1'b1;
        default: begin
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          now_q <= in_now;
          gps_q <= in_gps;
        end
      end
      S_CHECK: begin
        priority if (!active) res_status_q <= ST_INACTIVE;
        else if (lead_expired) res_status_q <= ST_TIMEOUT;
        else                   res_status_q <= ST_UPDATED;
      end
      S_RADIO: begin
        dt_q    <= now_q - last_tick_q;
        fused_q <= gps_q;
      end
      S_WGT: begin
        if (in_near)      a_q <= W_NEAR;
        else if (!in_far) a_q <= '0;
      end
      S_WGT2:  a_q <= in_mid ? a_mid : a_far;
      S_FUSE2: acc_q <= mul_q[ACC_W-1:0];
      S_FUSE3: fused_q <= blend_sum[39:16];
      S_SM2:   acc_q <= mul_q[ACC_W-1:0];
      S_DIFF: begin
        neg_q  <= diff[RANGE_W];
        rate_q <= '0;
      end
      S_DIVLD: begin
        div_num_q <= mul_q[DIV_W-1:0];
        div_rem_q <= '0;
      end
      S_DIV: begin
        div_rem_q <= div_ge ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
        div_num_q <= {div_num_q[DIV_W-2:0], div_ge};
      end
      S_RATE:  rate_q <= neg_q ? rate_neg : rate_pos;
      S_SPEED: speed_q <= {1'b0, lead_speed_q};
      S_SP2:   speed_q <= speed_sp2;
      S_EMIT: begin
        if (emit_fire) begin
          out_user_q <= res_status_q;
          out_data_q <= (res_status_q == ST_UPDATED)
                        ? {6'd0, radio_ok_q, speed_q, rate_q, smoothed_range_q} : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== sim/range_fusion_speed_command_top_tb.sv =====
module range_fusion_speed_command_top_tb;
  import rfsc_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_SPARE = 2'd3;
  localparam int unsigned MAX_IDLE = 18;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam logic [RANGE_W-1:0] RANGE_TOP = 24'hFFFFFF;
  localparam int unsigned SMOOTH_Q16 = 19661;
  localparam int unsigned RADIO_HOLD_MS = 1000;
  localparam int unsigned LEAD_HOLD_MS = 2000;
  localparam int unsigned RADIO_LIMIT = 51200;

  typedef struct packed {
    logic [TYPE_W-1:0]  kind;
    logic [TIME_W-1:0]  now_ms;
    logic [RANGE_W-1:0] gps;
    logic [RANGE_W-1:0] radio;
  } event_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANGE_W-1:0]  fused;
    logic [RATE_W-1:0]   rate;
    logic [CMD_W-1:0]    speed;
    logic                radio_used;
  } command_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [TYPE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]   m_axis_tuser;

  range_fusion_speed_command_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // controller settings as last written
  logic                law_enable = 1'b0;
  logic [SPEED_W-1:0]  law_lead = 16'd5120;
  logic [RANGE_W-1:0]  law_intercept = 24'd25600;
  logic [RANGE_W-1:0]  law_transition = 24'd7680;
  logic [RANGE_W-1:0]  law_offset = 24'd2560;
  logic [SPEED_W-1:0]  law_min = 16'd256;
  logic [SPEED_W-1:0]  law_max = 16'd2560;
  logic [SPEED_W-1:0]  law_approach = 16'd7680;

  // lead and range tracking
  logic                lead_ok = 1'b0;
  logic [TIME_W-1:0]   lead_stamp = '0;
  logic [RANGE_W-1:0]  radio_val = '0;
  logic                radio_ok = 1'b0;
  logic [TIME_W-1:0]   radio_stamp = '0;
  logic [RANGE_W-1:0]  smooth_rng = '0;
  logic                smooth_on = 1'b0;
  logic [RANGE_W-1:0]  prev_rng = '0;
  logic                prev_on = 1'b0;
  logic [TIME_W-1:0]   tick_stamp = '0;

  event_t       events_q[$];
  command_t     commands_q[$];
  event_t       drv_event = '0;
  command_t     cmd_next;
  command_t     cmd_want;
  bit           drv_busy = 1'b0;
  int unsigned  drv_gap = 0;
  int unsigned  rcv_stall = 0;
  bit           in_taken = 1'b0;
  bit           out_taken = 1'b0;
  bit           send_idles = 1'b1;
  bit           take_stalls = 1'b1;
  int unsigned  bad_beats = 0;
  logic [TIME_W-1:0]  clock_ms = '0;
  logic [RANGE_W-1:0] gps_track = '0;

  function automatic logic [WGT_W-1:0] radio_weight_q16(input logic [RANGE_W-1:0] r);
    logic [63:0] d;
    d = 64'(r);
    if (r < 24'd12800) return 17'd52429;
    if (r < 24'd25600) begin
      d = ((d - 64'd12800) * 64'd1536 + 64'd500) / 64'd1000;
      return 17'(64'd52429 - d);
    end
    if (r < RADIO_LIMIT) begin
      d = ((d - 64'd25600) * 64'd128 + 64'd50) / 64'd100;
      return (d >= 64'd32768) ? 17'd0 : 17'(64'd32768 - d);
    end
    return 17'd0;
  endfunction

  function automatic logic [CMD_W-1:0] speed_for(input logic [RANGE_W-1:0] r);
    logic [63:0] tc;
    logic [63:0] ds;
    if (r > law_intercept) begin
      tc = (64'(r) + 64'd5) / 64'd10;
      if (tc < 64'(law_min)) tc = 64'(law_min);
      else if (tc > 64'(law_max)) tc = 64'(law_max);
      ds = 64'(law_lead) + tc;
      if (ds > 64'(law_approach)) ds = 64'(law_approach);
    end else if (r > law_transition) begin
      if (r > law_offset) tc = (64'(r) - 64'(law_offset) + 64'd2) / 64'd5;
      else tc = 64'd0;
      if (tc < 64'(law_min)) tc = 64'(law_min);
      ds = 64'(law_lead) + tc;
    end else begin
      ds = 64'(law_lead);
    end
    return (ds > 64'd131071) ? 17'h1FFFF : ds[16:0];
  endfunction

  function automatic bit fuse_and_command(input event_t ev, output command_t cmd);
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  age;
    logic [WGT_W-1:0]   wgt;
    logic [63:0]        acc;
    logic [RANGE_W-1:0] fused;
    longint             rate;
    cmd = '0;
    case (ev.kind)
      REQ_LEAD: begin
        lead_ok = 1'b1;
        lead_stamp = ev.now_ms;
        return 1'b0;
      end
      REQ_RADIO: begin
        if (ev.radio != '0 && ev.radio < RADIO_LIMIT) begin
          radio_val = ev.radio;
          radio_ok = 1'b1;
          radio_stamp = ev.now_ms;
        end
        return 1'b0;
      end
      REQ_TICK: ;
      default: return 1'b0;
    endcase
    if (!law_enable || !lead_ok) begin
      cmd.status = ST_INACTIVE;
      return 1'b1;
    end
    dt = ev.now_ms - tick_stamp;
    age = ev.now_ms - lead_stamp;
    if (age > LEAD_HOLD_MS) begin
      lead_ok = 1'b0;
      cmd.status = ST_TIMEOUT;
      return 1'b1;
    end
    age = ev.now_ms - radio_stamp;
    if (age > RADIO_HOLD_MS) radio_ok = 1'b0;
    if (radio_ok) begin
      wgt = radio_weight_q16(ev.gps);
      acc = 64'(wgt) * 64'(radio_val) + (64'd65536 - 64'(wgt)) * 64'(ev.gps) + 64'd32768;
      fused = acc[39:16];
    end else begin
      fused = ev.gps;
    end
    if (!smooth_on) begin
      smooth_rng = fused;
      smooth_on = 1'b1;
    end else begin
      acc = 64'(SMOOTH_Q16) * 64'(fused) + 64'(65536 - SMOOTH_Q16) * 64'(smooth_rng)
          + 64'd32768;
      smooth_rng = acc[39:16];
    end
    rate = 0;
    if (dt != '0 && prev_on) begin
      rate = (longint'(prev_rng) - longint'(smooth_rng)) * 1000;
      rate = rate / longint'(dt);
      if (rate > 64'sd8388607) rate = 64'sd8388607;
      if (rate < -64'sd8388608) rate = -64'sd8388608;
    end
    prev_rng = smooth_rng;
    prev_on = 1'b1;
    tick_stamp = ev.now_ms;
    cmd.status = ST_UPDATED;
    cmd.fused = smooth_rng;
    cmd.rate = rate[23:0];
    cmd.speed = speed_for(smooth_rng);
    cmd.radio_used = radio_ok;
    return 1'b1;
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      bad_beats++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_taken = 1'b1;
        if (commands_q.size() == 0) begin
          $error("result beat with no command pending, tdata %h", m_axis_tdata);
          bad_beats++;
        end else begin
          cmd_want = commands_q.pop_front();
          compare_field("status", cmd_want.status, m_axis_tuser);
          compare_field("fused_range", cmd_want.fused, m_axis_tdata[23:0]);
          compare_field("closure_rate", longint'($signed(cmd_want.rate)),
                        longint'($signed(m_axis_tdata[47:24])));
          compare_field("speed_cmd", cmd_want.speed, m_axis_tdata[64:48]);
          compare_field("radio_used", cmd_want.radio_used, m_axis_tdata[65]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (fuse_and_command(drv_event, cmd_next)) commands_q.push_back(cmd_next);
        in_taken = 1'b1;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        in_taken = 1'b0;
        drv_busy = 1'b0;
        drv_gap = send_idles ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (!drv_busy) begin
        if (drv_gap != 0) begin
          drv_gap--;
        end else if (events_q.size() != 0) begin
          drv_event = events_q.pop_front();
          drv_busy = 1'b1;
        end
      end
      s_axis_tvalid <= drv_busy;
      s_axis_tdata <= {drv_event.radio, drv_event.gps, drv_event.now_ms};
      s_axis_tuser <= drv_event.kind;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        rcv_stall = take_stalls ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rcv_stall != 0) begin
        rcv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ENABLE:         law_enable = val[0];
      CFG_LEAD_SPEED:     law_lead = val[15:0];
      CFG_INTERCEPT_THR:  law_intercept = val;
      CFG_TRANSITION_THR: law_transition = val;
      CFG_FORM_OFFSET:    law_offset = val;
      CFG_MIN_CLOSURE:    law_min = val[15:0];
      CFG_MAX_CLOSURE:    law_max = val[15:0];
      CFG_MAX_APPROACH:   law_approach = val[15:0];
      default: ;
    endcase
  endtask

  task automatic load_law(input logic en, input logic [15:0] lead, input logic [23:0] icpt,
                          input logic [23:0] trans, input logic [23:0] offs,
                          input logic [15:0] cmin, input logic [15:0] cmax,
                          input logic [15:0] appr);
    write_reg(CFG_ENABLE, 24'(en));
    write_reg(CFG_LEAD_SPEED, 24'(lead));
    write_reg(CFG_INTERCEPT_THR, icpt);
    write_reg(CFG_TRANSITION_THR, trans);
    write_reg(CFG_FORM_OFFSET, offs);
    write_reg(CFG_MIN_CLOSURE, 24'(cmin));
    write_reg(CFG_MAX_CLOSURE, 24'(cmax));
    write_reg(CFG_MAX_APPROACH, 24'(appr));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_event(input logic [TYPE_W-1:0] kind, input logic [TIME_W-1:0] now_ms,
                            input logic [RANGE_W-1:0] gps, input logic [RANGE_W-1:0] radio);
    event_t ev;
    ev.kind = kind;
    ev.now_ms = now_ms;
    ev.gps = gps;
    ev.radio = radio;
    events_q.push_back(ev);
  endtask

  // wait for every command, then let any ignored beat drain out of the block
  task automatic settle();
    while (events_q.size() != 0 || drv_busy || commands_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_flight(input int unsigned n);
    int unsigned pick;
    int          sample;
    event_t      ev;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 3) clock_ms += $urandom_range(900, 2600);
      else clock_ms += $urandom_range(0, 6);
      ev.now_ms = clock_ms;
      ev.gps = 24'($urandom());
      ev.radio = 24'($urandom());
      if (pick < 12) begin
        ev.kind = REQ_LEAD;
      end else if (pick < 37) begin
        ev.kind = REQ_RADIO;
        case ($urandom_range(0, 9))
          0: ev.radio = '0;
          1: ev.radio = 24'($urandom_range(RADIO_LIMIT, RANGE_TOP));
          2: ;
          default: begin
            sample = int'(gps_track) + int'($urandom_range(0, 6000)) - 3000;
            if (sample < 1) sample = 1;
            if (sample >= int'(RADIO_LIMIT)) sample = int'(RADIO_LIMIT) - 1;
            ev.radio = 24'(sample);
          end
        endcase
      end else if (pick < 97) begin
        ev.kind = REQ_TICK;
        if ($urandom_range(0, 99) < 8) begin
          case ($urandom_range(0, 3))
            0: gps_track = 24'($urandom_range(0, 12799));
            1: gps_track = 24'($urandom_range(12800, 25599));
            2: gps_track = 24'($urandom_range(25600, RADIO_LIMIT - 1));
            default: gps_track = 24'($urandom_range(RADIO_LIMIT, RANGE_TOP));
          endcase
        end else begin
          sample = int'(gps_track) + int'($urandom_range(0, 512)) - 256;
          if (sample < 0) sample = 0;
          if (sample > int'(RANGE_TOP)) sample = int'(RANGE_TOP);
          gps_track = 24'(sample);
        end
        ev.gps = gps_track;
      end else begin
        ev.kind = REQ_SPARE;
      end
      events_q.push_back(ev);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_event(REQ_SPARE, 32'hFFFF_FFFF, RANGE_TOP, RANGE_TOP);
    push_event(REQ_TICK, 32'd0, 24'd0, 24'd0);
    settle();
    load_law(1'b1, RST_LEAD_SPEED, RST_INTERCEPT_THR, RST_TRANSITION_THR, RST_FORM_OFFSET,
             RST_MIN_CLOSURE, RST_MAX_CLOSURE, RST_MAX_APPROACH);

    t0 = 32'h8000_0000;
    push_event(REQ_TICK, t0, 24'd1000, 24'd0);
    push_event(REQ_LEAD, t0, 24'd0, 24'd0);
    push_event(REQ_RADIO, t0, 24'd0, 24'd0);
    push_event(REQ_RADIO, t0, 24'd0, 24'd51200);
    push_event(REQ_RADIO, t0 + 1, 24'd0, 24'd51199);
    push_event(REQ_TICK, t0 + 2, 24'd0, 24'd0);
    push_event(REQ_TICK, t0 + 2, 24'd12799, 24'd0);
    push_event(REQ_TICK, t0 + 4, 24'd12800, 24'd0);
    push_event(REQ_TICK, t0 + 6, 24'd25599, 24'd0);
    push_event(REQ_TICK, t0 + 8, 24'd25600, 24'd0);
    push_event(REQ_TICK, t0 + 10, 24'd51199, 24'd0);
    push_event(REQ_TICK, t0 + 12, 24'd51200, 24'd0);
    push_event(REQ_TICK, t0 + 14, RANGE_TOP, 24'd0);
    push_event(REQ_TICK, t0 + 16, 24'd0, 24'd0);
    push_event(REQ_RADIO, t0 + 20, 24'd0, 24'd1);
    push_event(REQ_LEAD, t0 + 21, 24'd0, 24'd0);
    push_event(REQ_TICK, t0 + 1020, 24'd5000, 24'd0);
    push_event(REQ_TICK, t0 + 1021, 24'd5000, 24'd0);
    push_event(REQ_TICK, t0 + 2021, 24'd5000, 24'd0);
    push_event(REQ_TICK, t0 + 2022, 24'd5000, 24'd0);
    push_event(REQ_TICK, t0 + 2023, 24'd5000, 24'd0);
    push_event(REQ_LEAD, 32'hFFFF_FFFE, 24'd0, 24'd0);
    push_event(REQ_RADIO, 32'hFFFF_FFFF, 24'd0, 24'd25600);
    push_event(REQ_TICK, 32'd3, 24'd30000, 24'd0);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: load_law(1'b1, RST_LEAD_SPEED, RST_INTERCEPT_THR, RST_TRANSITION_THR,
                    RST_FORM_OFFSET, RST_MIN_CLOSURE, RST_MAX_CLOSURE, RST_MAX_APPROACH);
        1: load_law(1'b1, 16'hFFFF, 24'd51200, 24'd12800, RANGE_TOP,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: load_law(1'b1, 16'hFFFF, RANGE_TOP, 24'd0, 24'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        3: load_law(1'b1, '0, '0, '0, '0, '0, '0, '0);
        4: load_law(1'b0, 16'($urandom()), 24'($urandom()), 24'($urandom()),
                    24'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()));
        5: load_law(1'b1, 16'd5120, 24'd20000, 24'd6000, 24'd3000,
                    16'd3000, 16'd1000, 16'd9000);
        default: load_law(1'b1, 16'($urandom_range(0, 65535)),
                          24'($urandom_range(0, 80000)), 24'($urandom_range(0, 40000)),
                          24'($urandom_range(0, 30000)), 16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 6000)), 16'($urandom_range(0, 65535)));
      endcase
      send_idles = (ph % 4 == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      take_stalls = (ph % 4 == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      clock_ms = (ph == 6) ? 32'hFFFF_F000 : $urandom();
      gps_track = 24'($urandom_range(0, 60000));
      queue_flight((ph == 4) ? 60 : 170);
      settle();
    end

    if (bad_beats == 0) begin
      $display("range_fusion_speed_command_top regression: pass");
    end else begin
      $display("range_fusion_speed_command_top regression: fail");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("range_fusion_speed_command_top regression: fail");
    $finish;
  end

endmodule
